FILE: rtl/ashc_pkg.sv
// Shared types and constants for the averaged sensor hysteresis controller.
// Depends on nothing; imported by the top level, ashc_front and ashc_back.
package ashc_pkg;

    localparam int IN_W        = 10;  // width of each raw sample port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int DUTY_W      = 7;
    localparam int PCT_W       = 8;
    localparam int TOUCH_PCT_W = 7;
    localparam int FLOOR_W     = 10;

    localparam logic [DUTY_W-1:0] DUTY_MAX  = 7'd100;
    localparam logic [PCT_W-1:0]  SCALE_100 = 8'd100;

    localparam logic [PCT_W-1:0]       LIGHT_OFF_RST = 8'd110;
    localparam logic [PCT_W-1:0]       LIGHT_ON_RST  = 8'd180;
    localparam logic [PCT_W-1:0]       TEMP_OFF_RST  = 8'd102;
    localparam logic [PCT_W-1:0]       TEMP_ON_RST   = 8'd104;
    localparam logic [TOUCH_PCT_W-1:0] TOUCH_PCT_RST = 7'd78;
    localparam logic [FLOOR_W-1:0]     DIM_FLOOR_RST = 10'd350;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT_OFF = 3'd0,
        CFG_LIGHT_ON  = 3'd1,
        CFG_TEMP_OFF  = 3'd2,
        CFG_TEMP_ON   = 3'd3,
        CFG_TOUCH_PCT = 3'd4,
        CFG_DIM_FLOOR = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [PCT_W-1:0]       light_off_pct;
        logic [PCT_W-1:0]       light_on_pct;
        logic [PCT_W-1:0]       temp_off_pct;
        logic [PCT_W-1:0]       temp_on_pct;
        logic [TOUCH_PCT_W-1:0] touch_pct;
        logic [FLOOR_W-1:0]     dim_floor;
    } cfg_t;

endpackage

FILE: rtl/averaged_sensor_hysteresis_controller.sv
// Top level of the averaged sensor hysteresis controller.
// Depends on ashc_pkg, ashc_front, ashc_fifo and ashc_back.

// Takes one light/touch/temperature sample triple per transfer and averages
// every SAMPLES_PER_AVERAGE triples (truncated). The first averaged set is
// stored as the baseline and produces no result; each later set produces one
// result: an LED duty of 0..100 from the light average above dim_floor (full
// scale at floor plus 400), a light LED and a temperature LED that each follow
// a percentage-of-baseline hysteresis, and a motor direction that toggles once
// per touch press. The block accepts one triple every cycle unless a completed
// set waits on a full queue; the accumulate adders in the front part are
// combinational. The sums are captured at the transfer of the triple that
// completes a set; the result then passes the reciprocal divide into the queue,
// the product stage and the output register. A four-entry queue parts the
// averaging front from the compare back, so a stalled result channel backs up
// into the queue before the sample channel stalls. Configuration writes are
// always taken (ready is tied high) and apply to each set as it leaves the
// queue; write only while no set is in flight.
module averaged_sensor_hysteresis_controller
    import ashc_pkg::*;
#(
    parameter int SAMPLES_PER_AVERAGE = 5,
    parameter int ADC_BITS            = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // sample channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [IN_W-1:0]       light_sample,
    input  logic [IN_W-1:0]       touch_sample,
    input  logic [IN_W-1:0]       temp_sample,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DUTY_W-1:0]     pwm_duty,
    output logic                  light_led,
    output logic                  temp_led,
    output logic                  motor_reverse,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Only the low ADC_BITS of each sample port take part.
    localparam int SAMPLE_W = (ADC_BITS < IN_W) ? ADC_BITS : IN_W;
    localparam int FIFO_DEPTH = 4;

    cfg_t cfg_reg;

    logic                  push, fifo_full, fifo_pop, fifo_empty;
    logic [3*SAMPLE_W-1:0] push_data, pop_data;

    assign cfg_ready = 1'b1;

    // Register file: decode the index, drop writes beyond the list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.light_off_pct <= LIGHT_OFF_RST;
            cfg_reg.light_on_pct  <= LIGHT_ON_RST;
            cfg_reg.temp_off_pct  <= TEMP_OFF_RST;
            cfg_reg.temp_on_pct   <= TEMP_ON_RST;
            cfg_reg.touch_pct     <= TOUCH_PCT_RST;
            cfg_reg.dim_floor     <= DIM_FLOOR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LIGHT_OFF: cfg_reg.light_off_pct <= cfg_data[PCT_W-1:0];
                CFG_LIGHT_ON:  cfg_reg.light_on_pct  <= cfg_data[PCT_W-1:0];
                CFG_TEMP_OFF:  cfg_reg.temp_off_pct  <= cfg_data[PCT_W-1:0];
                CFG_TEMP_ON:   cfg_reg.temp_on_pct   <= cfg_data[PCT_W-1:0];
                CFG_TOUCH_PCT: cfg_reg.touch_pct     <= cfg_data[TOUCH_PCT_W-1:0];
                CFG_DIM_FLOOR: cfg_reg.dim_floor     <= cfg_data[FLOOR_W-1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Accumulate and average; push one averaged set per completed group.
    ashc_front #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
        .SAMPLE_W            (SAMPLE_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .light_sample (light_sample),
        .touch_sample (touch_sample),
        .temp_sample  (temp_sample),
        .push         (push),
        .push_data    (push_data),
        .fifo_full    (fifo_full)
    );

    // Hold averaged sets while the back part waits on the result channel.
    ashc_fifo #(
        .WIDTH (3*SAMPLE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .pop_data  (pop_data),
        .empty     (fifo_empty)
    );

    // Capture the baseline, then compare and advance the LED and motor state.
    ashc_back #(
        .SAMPLE_W (SAMPLE_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .fifo_empty    (fifo_empty),
        .fifo_data     (pop_data),
        .fifo_pop      (fifo_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pwm_duty      (pwm_duty),
        .light_led     (light_led),
        .temp_led      (temp_led),
        .motor_reverse (motor_reverse)
    );

endmodule

FILE: rtl/ashc_fifo.sv
// Small register-based queue between the front and back parts.
// Depends on nothing outside this file.
module ashc_fifo #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W:0]   rd_ptr_reg, rd_ptr_next;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W])
                && (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]);
    assign pop_data = entry_reg[rd_ptr_reg[PTR_W-1:0]];

    assign wr_ptr_next = wr_ptr_reg + {{PTR_W{1'b0}}, 1'b1};
    assign rd_ptr_next = rd_ptr_reg + {{PTR_W{1'b0}}, 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= wr_ptr_next;
            if (pop && !empty)
                rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            entry_reg[wr_ptr_reg[PTR_W-1:0]] <= push_data;
    end

endmodule

FILE: rtl/ashc_front.sv
// Front part: accumulate sample triples, form truncated averages per set.
// Depends on ashc_pkg; feeds ashc_fifo.
module ashc_front
    import ashc_pkg::*;
#(
    parameter int SAMPLES_PER_AVERAGE = 5,
    parameter int SAMPLE_W            = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [IN_W-1:0]       light_sample,
    input  logic [IN_W-1:0]       touch_sample,
    input  logic [IN_W-1:0]       temp_sample,
    output logic                  push,
    output logic [3*SAMPLE_W-1:0] push_data,
    input  logic                  fifo_full
);

    localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int CNT_W = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
    // Exact reciprocal: m = ceil(2^S / N) with S covering the sum plus 3 bits.
    localparam int    MUL_S = SUM_W + 3;
    localparam int    M_W   = MUL_S + 1;
    localparam longint RECIP = ((longint'(1) << MUL_S) + SAMPLES_PER_AVERAGE - 1)
                               / SAMPLES_PER_AVERAGE;
    localparam logic [M_W-1:0]   RECIP_V = M_W'(RECIP);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_AVERAGE - 1);

    logic [SUM_W-1:0] light_sum_reg, touch_sum_reg, temp_sum_reg;
    logic [SUM_W-1:0] light_sum_next, touch_sum_next, temp_sum_next;
    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] light_done_reg, touch_done_reg, temp_done_reg;
    logic             done_valid_reg;
    logic             accept, last;

    logic [SUM_W+M_W-1:0] light_prod, touch_prod, temp_prod;

    assign in_stall = done_valid_reg && fifo_full;
    assign accept   = in_valid && !in_stall;
    assign last     = (count_reg == LAST_CNT);
    assign push     = done_valid_reg;

    assign light_sum_next = light_sum_reg + SUM_W'(light_sample[SAMPLE_W-1:0]);
    assign touch_sum_next = touch_sum_reg + SUM_W'(touch_sample[SAMPLE_W-1:0]);
    assign temp_sum_next  = temp_sum_reg  + SUM_W'(temp_sample[SAMPLE_W-1:0]);

    // Divide by the set size through the reciprocal product.
    assign light_prod = (SUM_W+M_W)'(light_done_reg) * (SUM_W+M_W)'(RECIP_V);
    assign touch_prod = (SUM_W+M_W)'(touch_done_reg) * (SUM_W+M_W)'(RECIP_V);
    assign temp_prod  = (SUM_W+M_W)'(temp_done_reg)  * (SUM_W+M_W)'(RECIP_V);

    assign push_data = {light_prod[MUL_S +: SAMPLE_W],
                        touch_prod[MUL_S +: SAMPLE_W],
                        temp_prod[MUL_S +: SAMPLE_W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_sum_reg  <= '0;
            touch_sum_reg  <= '0;
            temp_sum_reg   <= '0;
            count_reg      <= '0;
            done_valid_reg <= 1'b0;
        end
        else
        begin
            if (push && !fifo_full)
                done_valid_reg <= 1'b0;
            if (accept)
            begin
                if (last)
                begin
                    light_sum_reg  <= '0;
                    touch_sum_reg  <= '0;
                    temp_sum_reg   <= '0;
                    count_reg      <= '0;
                    done_valid_reg <= 1'b1;
                end
                else
                begin
                    light_sum_reg <= light_sum_next;
                    touch_sum_reg <= touch_sum_next;
                    temp_sum_reg  <= temp_sum_next;
                    count_reg     <= count_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last)
        begin
            light_done_reg <= light_sum_next;
            touch_done_reg <= touch_sum_next;
            temp_done_reg  <= temp_sum_next;
        end
    end

endmodule

FILE: rtl/ashc_back.sv
// Back part: baseline capture, scaled products, hysteresis and motor toggle.
// Depends on ashc_pkg; drains ashc_fifo and drives the result channel.
module ashc_back
    import ashc_pkg::*;
#(
    parameter int SAMPLE_W = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  fifo_empty,
    input  logic [3*SAMPLE_W-1:0] fifo_data,
    output logic                  fifo_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DUTY_W-1:0]     pwm_duty,
    output logic                  light_led,
    output logic                  temp_led,
    output logic                  motor_reverse
);

    localparam int PROD_W = SAMPLE_W + PCT_W;
    localparam int DIFF_W = (SAMPLE_W > FLOOR_W) ? SAMPLE_W : FLOOR_W;
    localparam int QUO_W  = DIFF_W - 2;

    logic [SAMPLE_W-1:0] light_avg, touch_avg, temp_avg;
    logic                advance;

    logic                baseline_valid_reg;
    logic [SAMPLE_W-1:0] base_light_reg, base_touch_reg, base_temp_reg;

    logic              s1_valid_reg, s1_result_reg;
    logic [PROD_W-1:0] l100_reg, h100_reg, t100_reg;
    logic [PROD_W-1:0] loff_reg, lon_reg, toff_reg, ton_reg, tch_reg;
    logic [DUTY_W-1:0] duty_reg;

    logic              out_valid_reg;
    logic [DUTY_W-1:0] pwm_duty_reg;
    logic              light_led_reg, temp_led_reg, motor_dir_reg, latched_dir_reg;

    logic [DIFF_W-1:0] light_ext, floor_ext, diff;
    logic [QUO_W-1:0]  quo;
    logic [DUTY_W-1:0] duty_next;

    assign {light_avg, touch_avg, temp_avg} = fifo_data;

    // Whole back pipeline moves when the output register can take a transfer.
    assign advance  = !out_valid_reg || !out_stall;
    assign fifo_pop = advance && !fifo_empty;

    // (light - floor) * 100 / 400 reduces to a drop of two bits.
    assign light_ext = DIFF_W'(light_avg);
    assign floor_ext = DIFF_W'(cfg.dim_floor);
    assign diff      = light_ext - floor_ext;
    assign quo       = diff[DIFF_W-1:2];

    always_comb
    begin
        if (light_ext <= floor_ext)
            duty_next = '0;
        else if (quo > QUO_W'(DUTY_MAX))
            duty_next = DUTY_MAX;
        else
            duty_next = DUTY_W'(quo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_valid_reg <= 1'b0;
            base_light_reg     <= '0;
            base_touch_reg     <= '0;
            base_temp_reg      <= '0;
            s1_valid_reg       <= 1'b0;
            s1_result_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
            light_led_reg      <= 1'b0;
            temp_led_reg       <= 1'b0;
            motor_dir_reg      <= 1'b0;
            latched_dir_reg    <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= fifo_pop;
            s1_result_reg <= fifo_pop && baseline_valid_reg;
            if (fifo_pop && !baseline_valid_reg)
            begin
                base_light_reg     <= light_avg;
                base_touch_reg     <= touch_avg;
                base_temp_reg      <= temp_avg;
                baseline_valid_reg <= 1'b1;
            end

            out_valid_reg <= s1_valid_reg && s1_result_reg;
            if (s1_valid_reg && s1_result_reg)
            begin
                priority if (l100_reg > loff_reg && l100_reg < lon_reg)
                    light_led_reg <= light_led_reg;
                else if (l100_reg >= lon_reg)
                    light_led_reg <= 1'b1;
                else if (l100_reg <= loff_reg)
                    light_led_reg <= 1'b0;

                priority if (h100_reg >= toff_reg && h100_reg <= ton_reg)
                    temp_led_reg <= temp_led_reg;
                else if (h100_reg > ton_reg)
                    temp_led_reg <= 1'b1;
                else
                    temp_led_reg <= 1'b0;

                // Toggle once per press against the direction latched on release.
                if (t100_reg <= tch_reg)
                    motor_dir_reg <= !latched_dir_reg;
                else
                    latched_dir_reg <= motor_dir_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            l100_reg <= PROD_W'(light_avg) * PROD_W'(SCALE_100);
            h100_reg <= PROD_W'(temp_avg)  * PROD_W'(SCALE_100);
            t100_reg <= PROD_W'(touch_avg) * PROD_W'(SCALE_100);
            loff_reg <= PROD_W'(base_light_reg) * PROD_W'(cfg.light_off_pct);
            lon_reg  <= PROD_W'(base_light_reg) * PROD_W'(cfg.light_on_pct);
            toff_reg <= PROD_W'(base_temp_reg)  * PROD_W'(cfg.temp_off_pct);
            ton_reg  <= PROD_W'(base_temp_reg)  * PROD_W'(cfg.temp_on_pct);
            tch_reg  <= PROD_W'(base_touch_reg) * PROD_W'(cfg.touch_pct);
            duty_reg <= duty_next;
            pwm_duty_reg <= duty_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pwm_duty      = pwm_duty_reg;
    assign light_led     = light_led_reg;
    assign temp_led      = temp_led_reg;
    assign motor_reverse = motor_dir_reg;

endmodule

FILE: dv/tb_averaged_sensor_hysteresis_controller.sv
// Self-checking bench for averaged_sensor_hysteresis_controller: averaged duty, LED hysteresis
// and motor toggling, checked in order against an in-bench prediction.
// Depends on ashc_pkg and the RTL of the block; needs nothing else.
module tb_averaged_sensor_hysteresis_controller;
    import ashc_pkg::*;

    localparam int SET_LEN        = 5;      // triples per averaged set
    localparam int SUM_W          = 13;
    localparam int ADC_FULL       = (1 << IN_W) - 1;
    localparam int DUTY_SPAN      = 400;    // light counts from floor to full duty
    localparam int PHASES         = 8;
    localparam int SETS_PER_PHASE = 30;
    localparam int DRAIN_CYCLES   = 10;     // margin after the last awaited result
    localparam int QUIET_LIMIT    = 2000;   // cycles with no transfer at all
    localparam int OPENING_ROWS   = 25;

    // Indexes past the register list; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              lamp;
        logic              warm;
        logic              reverse;
    } actuation_t;

    typedef struct packed {
        logic [IN_W-1:0] light;
        logic [IN_W-1:0] touch;
        logic [IN_W-1:0] temp;
        logic            known;   // expected actuation typed in below
        actuation_t      want;
    } sample_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [IN_W-1:0]       light_sample;
    logic [IN_W-1:0]       touch_sample;
    logic [IN_W-1:0]       temp_sample;
    logic                  out_valid;
    logic                  out_stall;
    logic [DUTY_W-1:0]     pwm_duty;
    logic                  light_led;
    logic                  temp_led;
    logic                  motor_reverse;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Travels with the payload so the monitor knows when a row carries a typed answer.
    logic                  row_known;
    actuation_t            row_want;

    averaged_sensor_hysteresis_controller #(
        .SAMPLES_PER_AVERAGE(SET_LEN),
        .ADC_BITS           (IN_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .light_sample (light_sample),
        .touch_sample (touch_sample),
        .temp_sample  (temp_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pwm_duty     (pwm_duty),
        .light_led    (light_led),
        .temp_led     (temp_led),
        .motor_reverse(motor_reverse),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction state: running sums, baseline, LED and motor state, and a
    // shadow of the registers. Updated only from observed transfers.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] sum_light;
    logic [SUM_W-1:0] sum_touch;
    logic [SUM_W-1:0] sum_temp;
    int               set_fill;
    bit               base_ready;
    logic [IN_W-1:0]  base_l;
    logic [IN_W-1:0]  base_t;
    logic [IN_W-1:0]  base_h;
    bit               lamp_on;
    bit               warm_on;
    bit               reverse_dir;
    bit               held_dir;     // direction captured on release
    cfg_t             shadow;

    actuation_t       awaited_actuations[$];

    int mismatches;
    int triples_taken;
    int results_checked;
    int writes_taken;
    int quiet_cycles;
    int tick;

    // Driver-side bookkeeping; kept apart from the prediction to avoid racing it.
    int sent_fill;
    int burst_left;
    bit lively;

    // Receiver stall pattern.
    int stall_mode;
    int stall_span;

    sample_row_t opening_rows [OPENING_ROWS];

    task automatic note_fault(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0d] %s", tick, msg);
    endtask

    task automatic absorb_write(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_LIGHT_OFF: shadow.light_off_pct = data[PCT_W-1:0];
            CFG_LIGHT_ON:  shadow.light_on_pct  = data[PCT_W-1:0];
            CFG_TEMP_OFF:  shadow.temp_off_pct  = data[PCT_W-1:0];
            CFG_TEMP_ON:   shadow.temp_on_pct   = data[PCT_W-1:0];
            CFG_TOUCH_PCT: shadow.touch_pct     = data[TOUCH_PCT_W-1:0];
            CFG_DIM_FLOOR: shadow.dim_floor     = data[FLOOR_W-1:0];
            default: ;
        endcase
    endtask

    // Fold one triple into the running average; when a set completes past the
    // baseline, work out the duty, both LEDs and the motor direction.
    task automatic fold_triple(input logic [IN_W-1:0] l, input logic [IN_W-1:0] t,
                               input logic [IN_W-1:0] h, output bit fires,
                               output actuation_t act);
        int avg_l;
        int avg_t;
        int avg_h;
        int l100;
        int t100;
        int h100;
        int l_off;
        int l_on;
        int h_off;
        int h_on;
        int press_mark;
        int span;
        fires = 1'b0;
        act = '0;
        sum_light = sum_light + l;
        sum_touch = sum_touch + t;
        sum_temp  = sum_temp + h;
        set_fill++;
        if (set_fill < SET_LEN)
            return;

        avg_l = int'(sum_light) / SET_LEN;
        avg_t = int'(sum_touch) / SET_LEN;
        avg_h = int'(sum_temp) / SET_LEN;
        sum_light = '0;
        sum_touch = '0;
        sum_temp  = '0;
        set_fill  = 0;

        // The first set only records the baseline.
        if (!base_ready) begin
            base_l = avg_l[IN_W-1:0];
            base_t = avg_t[IN_W-1:0];
            base_h = avg_h[IN_W-1:0];
            base_ready = 1'b1;
            return;
        end

        l100 = avg_l * int'(SCALE_100);
        t100 = avg_t * int'(SCALE_100);
        h100 = avg_h * int'(SCALE_100);
        l_off = int'(base_l) * int'(shadow.light_off_pct);
        l_on  = int'(base_l) * int'(shadow.light_on_pct);
        h_off = int'(base_h) * int'(shadow.temp_off_pct);
        h_on  = int'(base_h) * int'(shadow.temp_on_pct);
        press_mark = int'(base_t) * int'(shadow.touch_pct);

        // Light: open band holds; on wins over off when the bands cross.
        if (l100 > l_off && l100 < l_on)
            lamp_on = lamp_on;
        else if (l100 >= l_on)
            lamp_on = 1'b1;
        else if (l100 <= l_off)
            lamp_on = 1'b0;

        // Temperature: closed band holds, anything else is decided by the on mark.
        if (h100 >= h_off && h100 <= h_on)
            warm_on = warm_on;
        else if (h100 > h_on)
            warm_on = 1'b1;
        else
            warm_on = 1'b0;

        // A press flips against the latched direction, so holding it does not retoggle.
        if (t100 <= press_mark)
            reverse_dir = ~held_dir;
        else
            held_dir = reverse_dir;

        if (avg_l <= int'(shadow.dim_floor)) begin
            span = 0;
        end else begin
            span = (avg_l - int'(shadow.dim_floor)) * int'(SCALE_100) / DUTY_SPAN;
            if (span > int'(DUTY_MAX))
                span = int'(DUTY_MAX);
        end

        act.duty    = DUTY_W'(span);
        act.lamp    = lamp_on;
        act.warm    = warm_on;
        act.reverse = reverse_dir;
        fires = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict on every input transfer, check every result transfer,
    // mirror every register write, and watch for a hang.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        bit         fires;
        actuation_t act;
        actuation_t hoped;
        bit         moved;
        tick++;
        if (rst_n) begin
            moved = 1'b0;

            if (cfg_valid && cfg_ready === 1'b1) begin
                absorb_write(cfg_index, cfg_data);
                writes_taken++;
                moved = 1'b1;
            end

            if (in_valid && in_stall === 1'b0) begin
                fold_triple(light_sample, touch_sample, temp_sample, fires, act);
                if (fires)
                    awaited_actuations.push_back(row_known ? row_want : act);
                triples_taken++;
                moved = 1'b1;
            end

            if (out_valid === 1'b1 && !out_stall) begin
                if (awaited_actuations.size() == 0) begin
                    note_fault($sformatf("unexpected result: duty %0d leds %b%b motor %b",
                                         pwm_duty, light_led, temp_led, motor_reverse));
                end else begin
                    hoped = awaited_actuations.pop_front();
                    if (pwm_duty !== hoped.duty)
                        note_fault($sformatf("result %0d pwm_duty: expected %0d got %0d",
                                             results_checked, hoped.duty, pwm_duty));
                    if (light_led !== hoped.lamp)
                        note_fault($sformatf("result %0d light_led: expected %b got %b",
                                             results_checked, hoped.lamp, light_led));
                    if (temp_led !== hoped.warm)
                        note_fault($sformatf("result %0d temp_led: expected %b got %b",
                                             results_checked, hoped.warm, temp_led));
                    if (motor_reverse !== hoped.reverse)
                        note_fault($sformatf("result %0d motor_reverse: expected %b got %b",
                                             results_checked, hoped.reverse, motor_reverse));
                end
                results_checked++;
                moved = 1'b1;
            end

            // Drop the run if nothing moves for too long.
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no transfer for %0d cycles, %0d results awaited",
                         quiet_cycles, awaited_actuations.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Receiver stall: switch among free running, light, heavy and periodic
    // stalls, each held for a random stretch.
    always @(posedge clk)
    begin
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(3, 0);
            stall_span <= $urandom_range(200, 20);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(3, 0) == 0);
            2:       out_stall <= ($urandom_range(1, 0) == 0);
            default: out_stall <= (tick % 7) < 5;
        endcase
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one triple and hold it until the block takes it. Between bursts the
    // sender may drop valid for a random pause.
    task automatic push_triple(input logic [IN_W-1:0] l, input logic [IN_W-1:0] t,
                               input logic [IN_W-1:0] h, input logic known,
                               input actuation_t want);
        int pause;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            pause = lively ? $urandom_range(5, 0) : 0;
            if (pause != 0) begin
                in_valid <= 1'b0;
                repeat (pause) @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        light_sample <= l;
        touch_sample <= t;
        temp_sample  <= h;
        row_known    <= known;
        row_want     <= want;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        burst_left--;
        sent_fill = (sent_fill + 1) % SET_LEN;
    endtask

    // Drop valid, let every awaited result arrive, then give the pipeline time
    // to empty of sets that produce nothing.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_actuations.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
    endtask

    // Load a register setting for one phase: all ones, all zeros, reset values,
    // crossed bands, then random.
    task automatic program_phase(input int phase);
        logic [CFG_DATA_W-1:0] fresh [6];
        for (int k = 0; k < 6; k++)
            fresh[k] = CFG_DATA_W'($urandom);
        case (phase)
            0: for (int k = 0; k < 6; k++) fresh[k] = '1;
            1: for (int k = 0; k < 6; k++) fresh[k] = '0;
            2: begin
                fresh[CFG_LIGHT_OFF] = CFG_DATA_W'(LIGHT_OFF_RST);
                fresh[CFG_LIGHT_ON]  = CFG_DATA_W'(LIGHT_ON_RST);
                fresh[CFG_TEMP_OFF]  = CFG_DATA_W'(TEMP_OFF_RST);
                fresh[CFG_TEMP_ON]   = CFG_DATA_W'(TEMP_ON_RST);
                fresh[CFG_TOUCH_PCT] = CFG_DATA_W'(TOUCH_PCT_RST);
                fresh[CFG_DIM_FLOOR] = CFG_DATA_W'(DIM_FLOOR_RST);
            end
            3: begin
                fresh[CFG_LIGHT_OFF] = 10'd200;
                fresh[CFG_LIGHT_ON]  = 10'd90;
                fresh[CFG_TEMP_OFF]  = 10'd120;
                fresh[CFG_TEMP_ON]   = 10'd95;
                fresh[CFG_TOUCH_PCT] = 10'd100;
                fresh[CFG_DIM_FLOOR] = 10'd0;
            end
            default: ;
        endcase
        write_reg(CFG_LIGHT_OFF, fresh[CFG_LIGHT_OFF]);
        write_reg(CFG_LIGHT_ON,  fresh[CFG_LIGHT_ON]);
        write_reg(CFG_TEMP_OFF,  fresh[CFG_TEMP_OFF]);
        write_reg(CFG_TEMP_ON,   fresh[CFG_TEMP_ON]);
        write_reg(CFG_TOUCH_PCT, fresh[CFG_TOUCH_PCT]);
        write_reg(CFG_DIM_FLOOR, fresh[CFG_DIM_FLOOR]);
        if (phase >= 3) begin
            write_reg(SPARE_IDX_LO, CFG_DATA_W'($urandom));
            write_reg(SPARE_IDX_HI, CFG_DATA_W'($urandom));
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int pct_of(input int base, input int pct);
        return base * pct / 100;
    endfunction

    function automatic logic [IN_W-1:0] near(input int center, input int reach);
        int lo;
        int hi;
        if (center > ADC_FULL)
            center = ADC_FULL;
        lo = center - reach;
        hi = center + reach;
        if (lo < 0)
            lo = 0;
        if (hi > ADC_FULL)
            hi = ADC_FULL;
        return IN_W'($urandom_range(hi, lo));
    endfunction

    // Aim the light average anywhere, across the duty ramp, or onto an LED mark.
    function automatic int aim_light();
        case ($urandom_range(3, 0))
            0:       return $urandom_range(ADC_FULL, 0);
            1:       return int'(shadow.dim_floor) + $urandom_range(420, 0);
            2:       return near(pct_of(base_l, shadow.light_off_pct), 2);
            default: return near(pct_of(base_l, shadow.light_on_pct), 2);
        endcase
    endfunction

    function automatic int aim_temp();
        case ($urandom_range(2, 0))
            0:       return $urandom_range(ADC_FULL, 0);
            1:       return near(pct_of(base_h, shadow.temp_off_pct), 2);
            default: return near(pct_of(base_h, shadow.temp_on_pct), 2);
        endcase
    endfunction

    // Touch: right at the press mark, firmly pressed, released, or anywhere.
    function automatic int aim_touch();
        int mark;
        mark = pct_of(base_t, shadow.touch_pct);
        case ($urandom_range(3, 0))
            0:       return near(mark, 2);
            1:       return $urandom_range(mark > ADC_FULL ? ADC_FULL : mark, 0);
            2:       return near(mark + $urandom_range(300, 5), 0);
            default: return $urandom_range(ADC_FULL, 0);
        endcase
    endfunction

    // Send the triples that complete the current set: mostly samples clustered
    // around chosen aims, some pure noise, some with one wild sample.
    task automatic run_set(input int count);
        int la;
        int ta;
        int ha;
        int spread;
        int shape;
        int wild;
        la = aim_light();
        ta = aim_touch();
        ha = aim_temp();
        shape = $urandom_range(19, 0);
        wild = $urandom_range(count - 1, 0);
        case ($urandom_range(4, 0))
            0, 1:    spread = 0;
            2:       spread = 1;
            3:       spread = 3;
            default: spread = 30;
        endcase
        for (int k = 0; k < count; k++) begin
            if (shape < 2 || (shape == 2 && k == wild))
                push_triple(IN_W'($urandom), IN_W'($urandom), IN_W'($urandom), 1'b0, '0);
            else
                push_triple(near(la, spread), near(ta, spread), near(ha, spread), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int tail;
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        light_sample = '0;
        touch_sample = '0;
        temp_sample  = '0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        row_known    = 1'b0;
        row_want     = '0;

        sum_light   = '0;
        sum_touch   = '0;
        sum_temp    = '0;
        set_fill    = 0;
        base_ready  = 1'b0;
        base_l      = '0;
        base_t      = '0;
        base_h      = '0;
        lamp_on     = 1'b0;
        warm_on     = 1'b0;
        reverse_dir = 1'b0;
        held_dir    = 1'b0;
        shadow = '{LIGHT_OFF_RST, LIGHT_ON_RST, TEMP_OFF_RST, TEMP_ON_RST,
                   TOUCH_PCT_RST, DIM_FLOOR_RST};

        mismatches      = 0;
        triples_taken   = 0;
        results_checked = 0;
        writes_taken    = 0;
        quiet_cycles    = 0;
        tick            = 0;
        sent_fill       = 0;
        burst_left      = 0;
        lively          = 1'b1;
        stall_mode      = 0;
        stall_span      = 0;

        // Directed opening, reset register values. The baseline set lands at
        // light 400, touch 600, temp 500 after truncation, which puts the light
        // marks at 440 and 720, the temperature band at 510..520 and the press
        // mark at 468.
        opening_rows = '{
            // baseline: truncated averages, extremes on touch and temperature
            '{10'd398,  10'd0,    10'd1023, 1'b0, '0},
            '{10'd399,  10'd1023, 10'd0,    1'b0, '0},
            '{10'd400,  10'd600,  10'd512,  1'b0, '0},
            '{10'd401,  10'd577,  10'd465,  1'b0, '0},
            '{10'd403,  10'd802,  10'd502,  1'b0, '0},
            // all full scale: duty clamps, both LEDs on, touch released
            '{10'd1023, 10'd1023, 10'd1023, 1'b0, '0},
            '{10'd1023, 10'd1023, 10'd1023, 1'b0, '0},
            '{10'd1023, 10'd1023, 10'd1023, 1'b0, '0},
            '{10'd1023, 10'd1023, 10'd1023, 1'b0, '0},
            '{10'd1023, 10'd1023, 10'd1023, 1'b1, '{7'd100, 1'b1, 1'b1, 1'b0}},
            // all zero: light below the floor, LEDs off, press reverses the motor
            '{10'd0,    10'd0,    10'd0,    1'b0, '0},
            '{10'd0,    10'd0,    10'd0,    1'b0, '0},
            '{10'd0,    10'd0,    10'd0,    1'b0, '0},
            '{10'd0,    10'd0,    10'd0,    1'b0, '0},
            '{10'd0,    10'd0,    10'd0,    1'b1, '{7'd0, 1'b0, 1'b0, 1'b1}},
            // inside both bands: LEDs hold, a held press does not toggle again
            '{10'd598,  10'd0,    10'd515,  1'b0, '0},
            '{10'd602,  10'd0,    10'd515,  1'b0, '0},
            '{10'd600,  10'd0,    10'd515,  1'b0, '0},
            '{10'd599,  10'd0,    10'd515,  1'b0, '0},
            '{10'd601,  10'd0,    10'd515,  1'b1, '{7'd62, 1'b0, 1'b0, 1'b1}},
            // exact marks: duty hits 100 at floor plus 400, temperature on the
            // upper band edge holds, touch one count above the press mark releases
            '{10'd750,  10'd469,  10'd520,  1'b0, '0},
            '{10'd750,  10'd469,  10'd520,  1'b0, '0},
            '{10'd750,  10'd469,  10'd520,  1'b0, '0},
            '{10'd750,  10'd469,  10'd520,  1'b0, '0},
            '{10'd750,  10'd469,  10'd520,  1'b1, '{7'd100, 1'b1, 1'b0, 1'b1}}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < OPENING_ROWS; r++)
            push_triple(opening_rows[r].light, opening_rows[r].touch, opening_rows[r].temp,
                        opening_rows[r].known, opening_rows[r].want);

        // Random phases. The baseline stays fixed for the whole run, so zero
        // marks are reached through zero percentages in the all-zero phase.
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            program_phase(phase);
            lively = ($urandom_range(3, 0) != 0);
            for (int s = 0; s < SETS_PER_PHASE; s++)
                run_set(SET_LEN - sent_fill);
            // Mostly leave a partial set behind so the next write lands mid-average.
            tail = $urandom_range(SET_LEN - 1, 0);
            if (tail != 0)
                run_set(tail);
        end
        settle();

        $display("%0d triples in %0d register phases, %0d averaged results compared,",
                 triples_taken, PHASES, results_checked);
        $display("%0d register writes, %0d faults", writes_taken, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
